FILE: hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W      = 16;
    localparam int DISC_W      = 34;
    localparam int ROOT_W      = 32;
    localparam int SQRT_STEPS  = 32;
    localparam int RAD_W       = 2 * SQRT_STEPS;
    localparam int SREM_W      = 35;
    localparam int MAG_W       = 33;
    localparam int DIV_STEPS   = MAG_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_LINEAR = 3'd0,
        ST_NONE   = 3'd1,
        ST_DOUBLE = 3'd2,
        ST_TWO    = 3'd3,
        ST_DEGEN  = 3'd4
    } t_status;

    // sqrt pipeline payload
    typedef struct packed {
        t_status                    status;
        logic signed [DISC_W-1:0]   disc;
        logic signed [COEF_W-1:0]   a;
        logic signed [COEF_W-1:0]   b;
        logic signed [COEF_W-1:0]   c;
        logic [RAD_W-1:0]           x;
        logic [SREM_W-1:0]          rem;
        logic [SQRT_STEPS-1:0]      root;
    } t_sq;

    // queued word: both divisions, as magnitudes and signs
    typedef struct packed {
        t_status                    status;
        logic signed [DISC_W-1:0]   disc;
        logic [COEF_W-1:0]          dv;
        logic                       neg_p;
        logic                       neg_m;
        logic [MAG_W-1:0]           num_p;
        logic [MAG_W-1:0]           num_m;
    } t_job;

    // divider pipeline payload
    typedef struct packed {
        t_status                    status;
        logic signed [DISC_W-1:0]   disc;
        logic [COEF_W-1:0]          dv;
        logic                       neg_p;
        logic                       neg_m;
        logic [MAG_W-1:0]           dp;
        logic [MAG_W-1:0]           dm;
        logic [COEF_W-1:0]          rp;
        logic [COEF_W-1:0]          rm;
    } t_div;

endpackage

FILE: hw/rtl/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_in_if / qrs_out_if
// Valid/ready channels for coefficient words and result words.
// ----------------------------------------------------------------------------
interface qrs_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] coef_a;
    logic signed [15:0] coef_b;
    logic signed [15:0] coef_c;

    modport source (output valid, coef_a, coef_b, coef_c, input ready);
    modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [33:0] discriminant;
    logic signed [31:0] root_plus;
    logic signed [31:0] root_minus;
    logic               saturated;

    modport source (output valid, status, discriminant, root_plus, root_minus, saturated,
                    input ready);
    modport sink   (input valid, status, discriminant, root_plus, root_minus, saturated,
                    output ready);
endinterface

FILE: hw/rtl/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Accepts coefficient words, forms the discriminant, classifies the equation
// and runs a one-bit-per-stage square root pipeline. Emits division jobs.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qrs_in_if.sink      i_in,
    input  logic        i_en,
    output logic        o_valid,
    output t_job        o_job
);

    logic                       r_v0, r_v1;
    logic signed [COEF_W-1:0]   r_a0, r_b0, r_c0;
    logic signed [COEF_W-1:0]   r_a1, r_b1, r_c1;
    logic signed [2*COEF_W-1:0] r_bb, r_ac;
    logic                       r_sv [SQRT_STEPS+1];
    t_sq                        r_sq [SQRT_STEPS+1];
    t_sq                        n_sq0;
    logic signed [DISC_W-1:0]   w_bb, w_ac, w_d;
    logic                       r_jv;
    t_job                       r_job, n_job;

    assign i_in.ready = i_en;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_jv <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_v0 <= i_in.valid;
            r_v1 <= r_v0;
            r_sv[0] <= r_v1;
            for (int k = 0; k < SQRT_STEPS; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
            r_jv <= r_sv[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0 <= i_in.coef_a;
            r_b0 <= i_in.coef_b;
            r_c0 <= i_in.coef_c;
            r_bb <= r_b0 * r_b0;
            r_ac <= r_a0 * r_c0;
            r_a1 <= r_a0;
            r_b1 <= r_b0;
            r_c1 <= r_c0;
            r_sq[0] <= n_sq0;
            r_job <= n_job;
        end
    end

    // discriminant and class
    always_comb begin
        w_bb = DISC_W'(r_bb);
        w_ac = DISC_W'(r_ac);
        w_d  = w_bb - (w_ac <<< 2);
        n_sq0 = '0;
        n_sq0.a = r_a1;
        n_sq0.b = r_b1;
        n_sq0.c = r_c1;
        n_sq0.disc = w_d;
        priority if (r_a1 == '0 && r_b1 == '0) begin
            n_sq0.status = ST_DEGEN;
            n_sq0.disc   = '0;
        end else if (r_a1 == '0) begin
            n_sq0.status = ST_LINEAR;
            n_sq0.disc   = '0;
        end else if (w_d < 0) begin
            n_sq0.status = ST_NONE;
        end else if (w_d == '0) begin
            n_sq0.status = ST_DOUBLE;
        end else begin
            n_sq0.status = ST_TWO;
            n_sq0.x = {1'b0, w_d[DISC_W-2:0], 30'd0};
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [SREM_W-1:0] trial, tsub;
        logic              take;
        t_sq               n_stage;

        always_comb begin
            trial = {r_sq[k].rem[SREM_W-3:0], r_sq[k].x[RAD_W-1 -: 2]};
            tsub  = {1'b0, r_sq[k].root, 2'b01};
            take  = (trial >= tsub);
            n_stage      = r_sq[k];
            n_stage.x    = {r_sq[k].x[RAD_W-3:0], 2'b00};
            n_stage.rem  = take ? (trial - tsub) : trial;
            n_stage.root = {r_sq[k].root[SQRT_STEPS-2:0], take};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k+1] <= n_stage;
            end
        end
    end

    // numerators and divisor
    always_comb begin
        logic signed [DISC_W-1:0] b34, c34, s34, base, np, nm, lp, sel;
        logic signed [COEF_W:0]   dv;
        logic [DISC_W-1:0]        mp, mm;
        logic [COEF_W:0]          md;
        b34  = DISC_W'(r_sq[SQRT_STEPS].b);
        c34  = DISC_W'(r_sq[SQRT_STEPS].c);
        s34  = {2'b00, r_sq[SQRT_STEPS].root};
        base = -(b34 <<< 15);
        np   = base + s34;
        nm   = base - s34;
        lp   = -(c34 <<< 16);
        sel  = (r_sq[SQRT_STEPS].status == ST_LINEAR) ? lp : np;
        dv   = (r_sq[SQRT_STEPS].status == ST_LINEAR) ? (COEF_W+1)'(r_sq[SQRT_STEPS].b)
                                                      : (COEF_W+1)'(r_sq[SQRT_STEPS].a);
        mp   = sel[DISC_W-1] ? DISC_W'(-sel) : DISC_W'(sel);
        mm   = nm[DISC_W-1]  ? DISC_W'(-nm)  : DISC_W'(nm);
        md   = dv[COEF_W]    ? (COEF_W+1)'(-dv) : (COEF_W+1)'(dv);
        n_job.status = r_sq[SQRT_STEPS].status;
        n_job.disc   = r_sq[SQRT_STEPS].disc;
        n_job.dv     = md[COEF_W-1:0];
        n_job.neg_p  = sel[DISC_W-1] ^ dv[COEF_W];
        n_job.neg_m  = nm[DISC_W-1] ^ dv[COEF_W];
        n_job.num_p  = mp[MAG_W-1:0];
        n_job.num_m  = mm[MAG_W-1:0];
    end

    assign o_valid = r_jv;
    assign o_job   = r_job;

endmodule

FILE: hw/rtl/qrs_queue.sv
// ----------------------------------------------------------------------------
// qrs_queue
// Small FIFO of division jobs between the front and back pipelines.
// ----------------------------------------------------------------------------
module qrs_queue import qrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_job    o_job
);

    t_job               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wp, r_rp;
    logic [QCNT_W-1:0]  r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

endmodule

FILE: hw/rtl/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back
// Two-lane restoring divider pipeline, sign fix, clamp and result register.
// ----------------------------------------------------------------------------
module qrs_back import qrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    qrs_out_if.source   o_out
);

    logic   w_en;
    logic   r_dvv [DIV_STEPS+1];
    t_div   r_dv  [DIV_STEPS+1];
    t_div   n_dv0;
    logic   r_ov;

    logic [2:0]                 r_status;
    logic signed [DISC_W-1:0]   r_disc;
    logic signed [ROOT_W-1:0]   r_rp, r_rm;
    logic                       r_sat;

    assign w_en  = !r_ov || o_out.ready;
    assign o_pop = w_en && i_valid;

    always_comb begin
        n_dv0 = '0;
        n_dv0.status = i_job.status;
        n_dv0.disc   = i_job.disc;
        n_dv0.dv     = i_job.dv;
        n_dv0.neg_p  = i_job.neg_p;
        n_dv0.neg_m  = i_job.neg_m;
        n_dv0.dp     = i_job.num_p;
        n_dv0.dm     = i_job.num_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) begin
                r_dvv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_dvv[0] <= i_valid;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dvv[k+1] <= r_dvv[k];
            end
            r_ov <= r_dvv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [COEF_W:0] tp, tm;
        logic            gp, gm;
        t_div            n_stage;

        always_comb begin
            tp = {r_dv[k].rp, r_dv[k].dp[MAG_W-1]};
            tm = {r_dv[k].rm, r_dv[k].dm[MAG_W-1]};
            gp = (tp >= {1'b0, r_dv[k].dv});
            gm = (tm >= {1'b0, r_dv[k].dv});
            n_stage    = r_dv[k];
            n_stage.dp = {r_dv[k].dp[MAG_W-2:0], gp};
            n_stage.dm = {r_dv[k].dm[MAG_W-2:0], gm};
            n_stage.rp = gp ? COEF_W'(tp - {1'b0, r_dv[k].dv}) : tp[COEF_W-1:0];
            n_stage.rm = gm ? COEF_W'(tm - {1'b0, r_dv[k].dv}) : tm[COEF_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[k+1] <= n_stage;
            end
        end
    end

    // sign, clamp, select
    always_ff @(posedge i_clk) begin
        logic signed [MAG_W:0]    qp, qm;
        logic                     sp, sm;
        logic signed [ROOT_W-1:0] cp, cm;
        qp = r_dv[DIV_STEPS].neg_p ? -$signed({1'b0, r_dv[DIV_STEPS].dp})
                                   :  $signed({1'b0, r_dv[DIV_STEPS].dp});
        qm = r_dv[DIV_STEPS].neg_m ? -$signed({1'b0, r_dv[DIV_STEPS].dm})
                                   :  $signed({1'b0, r_dv[DIV_STEPS].dm});
        sp = !((qp[MAG_W:ROOT_W-1] == '0) || (qp[MAG_W:ROOT_W-1] == '1));
        sm = !((qm[MAG_W:ROOT_W-1] == '0) || (qm[MAG_W:ROOT_W-1] == '1));
        cp = sp ? (qp[MAG_W] ? {1'b1, {(ROOT_W-1){1'b0}}} : {1'b0, {(ROOT_W-1){1'b1}}})
                : qp[ROOT_W-1:0];
        cm = sm ? (qm[MAG_W] ? {1'b1, {(ROOT_W-1){1'b0}}} : {1'b0, {(ROOT_W-1){1'b1}}})
                : qm[ROOT_W-1:0];
        if (w_en) begin
            r_status <= r_dv[DIV_STEPS].status;
            r_disc   <= r_dv[DIV_STEPS].disc;
            unique case (r_dv[DIV_STEPS].status)
                ST_LINEAR: begin
                    r_rp  <= cp;
                    r_rm  <= '0;
                    r_sat <= sp;
                end
                ST_DOUBLE, ST_TWO: begin
                    r_rp  <= cp;
                    r_rm  <= cm;
                    r_sat <= sp || sm;
                end
                default: begin
                    r_rp  <= '0;
                    r_rm  <= '0;
                    r_sat <= 1'b0;
                end
            endcase
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_status;
    assign o_out.discriminant = r_disc;
    assign o_out.root_plus    = r_rp;
    assign o_out.root_minus   = r_rm;
    assign o_out.saturated    = r_sat;

endmodule

FILE: hw/rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 from signed Q8.8 coefficients.
// ----------------------------------------------------------------------------
// Takes one equation per clock while the queue is not full, and returns one
// result word per equation, in order. A 32-stage square root pipeline in the
// front and a 33-stage divider pipeline in the back are joined by a four-word
// queue; the front keeps accepting while results wait until that queue is
// full. Results: status, discriminant in Q18.16, roots in saturating Q16.16
// truncated toward zero, and a saturation flag.
module quadratic_root_solver import qrs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qrs_in_if.sink      i_in,
    qrs_out_if.source   o_out
);

    logic   w_fv, w_full, w_qv, w_pop, w_push;
    t_job   w_fjob, w_qjob;

    assign w_push = w_fv && !w_full;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_en    (!w_full),
        .o_valid (w_fv),
        .o_job   (w_fjob)
    );

    qrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_qv),
        .o_job   (w_qjob)
    );

    qrs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qv),
        .i_job   (w_qjob),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

FILE: hw/rtl/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of result words, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker import qrs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready,
    input  logic [2:0]         i_status,
    input  logic signed [33:0] i_disc,
    input  logic signed [31:0] i_rp,
    input  logic signed [31:0] i_rm,
    input  logic               i_sat
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_rp) && $stable(i_status))
        else $error("result word changed while stalled");

    a_noroot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_NONE || i_status == ST_DEGEN)
        |-> i_rp == '0 && i_rm == '0 && !i_sat)
        else $error("roots reported without a real root");

    a_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == ST_LINEAR || i_status == ST_DEGEN)
        |-> i_disc == '0 && i_rm == '0)
        else $error("linear word carries discriminant or second root");

    a_double: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_DOUBLE |-> i_rp == i_rm && i_disc == '0)
        else $error("double root mismatch");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_status (o_out.status),
    .i_disc   (o_out.discriminant),
    .i_rp     (o_out.root_plus),
    .i_rm     (o_out.root_minus),
    .i_sat    (o_out.saturated)
);
